// ===== rtl/bap_pkg.sv =====
// Shared constants and types for the block-average pixelation block.
// Used by block_average_pixelate and by its port checker; no dependencies.
package bap_pkg;

  // Frame and block size limits.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MAX_BLOCK  = 64;

  // Field and counter widths.
  localparam int unsigned ColW     = $clog2(MAX_WIDTH);
  localparam int unsigned RowW     = $clog2(MAX_HEIGHT);
  localparam int unsigned OffW     = $clog2(MAX_BLOCK);
  localparam int unsigned SpanW    = 7;
  localparam int unsigned FrmCfgW  = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned PixW     = 8;
  localparam int unsigned SumW     = 20;
  localparam int unsigned CntW     = 2 * SpanW - 1;
  localparam int unsigned QuoW     = 8;
  localparam int unsigned StepW    = $clog2(QuoW);
  localparam int unsigned NumCh    = 4;

  // Register reset values.
  localparam logic [SpanW-1:0]   BlockWidthRst  = SpanW'(8);
  localparam logic [SpanW-1:0]   BlockHeightRst = SpanW'(8);
  localparam logic [FrmCfgW-1:0] FrameWidthRst  = FrmCfgW'(640);
  localparam logic [FrmCfgW-1:0] FrameHeightRst = FrmCfgW'(480);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgBlockWidth  = 3'd0,
    CfgBlockHeight = 3'd1,
    CfgFrameWidth  = 3'd2,
    CfgFrameHeight = 3'd3
  } cfg_idx_e;

  // Channel order in the lane arrays: red, green, blue, alpha.
  typedef logic [NumCh-1:0][PixW-1:0] pixel_t;
  typedef logic [NumCh-1:0][SumW-1:0] sums_t;
  typedef logic [NumCh-1:0][QuoW-1:0] quot_t;

endpackage

// ===== rtl/block_average_pixelate.sv =====
// Block-average pixelation over a raster RGBA pixel stream.
// Depends on bap_pkg; holds the per-block-column sum memory and the divider.
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_stall_o   red_i, green_i, blue_i, alpha_i
//   out      out        out_valid_o/out_stall_i origin, span, averages, last_block
//
// A pixel that does not complete a block is taken without a stall; the sum memory is read
// when the pixel is taken and written back in the next cycle, with forwarding.
// A pixel that completes a block holds off the input for the sum write-back and
// eight steps of the shared restoring divider, one quotient bit per step.
// Reset is asynchronous and active low; the sum memory is not cleared, since each
// block column is loaded at its top-left pixel. A stalled result holds the divider.
module block_average_pixelate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bap_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bap_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bap_pkg::PixW-1:0]      red_i,
  input  logic [bap_pkg::PixW-1:0]      green_i,
  input  logic [bap_pkg::PixW-1:0]      blue_i,
  input  logic [bap_pkg::PixW-1:0]      alpha_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bap_pkg::ColW-1:0]      origin_x_o,
  output logic [bap_pkg::RowW-1:0]      origin_y_o,
  output logic [bap_pkg::SpanW-1:0]     span_x_o,
  output logic [bap_pkg::SpanW-1:0]     span_y_o,
  output logic [bap_pkg::PixW-1:0]      avg_red_o,
  output logic [bap_pkg::PixW-1:0]      avg_green_o,
  output logic [bap_pkg::PixW-1:0]      avg_blue_o,
  output logic [bap_pkg::PixW-1:0]      avg_alpha_o,
  output logic                          last_block_o
);
  import bap_pkg::*;

  // Configuration registers.
  logic [SpanW-1:0]   block_width_q, block_height_q;
  logic [FrmCfgW-1:0] frame_width_q, frame_height_q;

  // Position counters.
  logic [ColW-1:0] col_q, bc_q;
  logic [RowW-1:0] row_q;
  logic [OffW-1:0] ox_q, oy_q;

  // Write-back stage.
  logic            s2_valid_q, s2_load_q, s2_done_q;
  logic [ColW-1:0] s2_addr_q;
  pixel_t          s2_px_q;
  sums_t           s2_sums;
  logic            fwd_q;
  sums_t           fwd_data_q;

  // Sum memory.
  sums_t sum_mem [MAX_WIDTH];
  sums_t mem_rdata_q;

  // Completed-block description, held while the divider runs.
  logic [ColW-1:0]  meta_ox_q;
  logic [RowW-1:0]  meta_oy_q;
  logic [SpanW-1:0] meta_sx_q, meta_sy_q;
  logic             meta_last_q;
  logic [CntW-1:0]  meta_cnt_q;

  // Divider.
  logic             div_busy_q;
  logic [StepW-1:0] div_step_q;
  sums_t            rem_q, rem_d;
  logic [SumW-1:0]  dvs_q;
  quot_t            quo_q, quo_d;
  logic             div_last, div_fire, div_finish, div_start;

  // Output register.
  logic             out_valid_q;
  logic [ColW-1:0]  origin_x_q;
  logic [RowW-1:0]  origin_y_q;
  logic [SpanW-1:0] span_x_q, span_y_q;
  quot_t            avg_q;
  logic             last_q;

  // Pixel view and handshakes.
  pixel_t           px_in;
  logic             accept, cfg_write, cfg_known;
  logic [SpanW-1:0] bw, bh, span_x, span_y;
  logic [FrmCfgW-1:0] fw, fh;
  logic             col_last, row_last, blkx_last, blky_last;
  logic             col_done, row_done, blk_done, frame_end;

  assign px_in       = {alpha_i, blue_i, green_i, red_i};
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign cfg_known   = (cfg_index_i == CfgBlockWidth) || (cfg_index_i == CfgBlockHeight) ||
                       (cfg_index_i == CfgFrameWidth) || (cfg_index_i == CfgFrameHeight);
  assign in_stall_o  = div_busy_q | (s2_valid_q & s2_done_q);
  assign accept      = in_valid_i & ~in_stall_o;

  // Size clamping: zero reads as one, oversize reads as the maximum.
  always_comb begin
    if (block_width_q == '0) bw = SpanW'(1);
    else if (block_width_q > SpanW'(MAX_BLOCK)) bw = SpanW'(MAX_BLOCK);
    else bw = block_width_q;
    if (block_height_q == '0) bh = SpanW'(1);
    else if (block_height_q > SpanW'(MAX_BLOCK)) bh = SpanW'(MAX_BLOCK);
    else bh = block_height_q;
    if (frame_width_q == '0) fw = FrmCfgW'(1);
    else if (frame_width_q > FrmCfgW'(MAX_WIDTH)) fw = FrmCfgW'(MAX_WIDTH);
    else fw = frame_width_q;
    if (frame_height_q == '0) fh = FrmCfgW'(1);
    else if (frame_height_q > FrmCfgW'(MAX_HEIGHT)) fh = FrmCfgW'(MAX_HEIGHT);
    else fh = frame_height_q;
  end

  // Edge and block-completion flags of the current pixel.
  assign span_x    = SpanW'(ox_q) + SpanW'(1);
  assign span_y    = SpanW'(oy_q) + SpanW'(1);
  assign col_last  = (FrmCfgW'(col_q) + FrmCfgW'(1)) >= fw;
  assign row_last  = (FrmCfgW'(row_q) + FrmCfgW'(1)) >= fh;
  assign blkx_last = span_x >= bw;
  assign blky_last = span_y >= bh;
  assign col_done  = blkx_last | col_last;
  assign row_done  = blky_last | row_last;
  assign blk_done  = col_done & row_done;
  assign frame_end = col_last & row_last;

  // Configuration registers; a known index restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_width_q  <= BlockWidthRst;
      block_height_q <= BlockHeightRst;
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CfgBlockWidth:  block_width_q  <= cfg_data_i[SpanW-1:0];
        CfgBlockHeight: block_height_q <= cfg_data_i[SpanW-1:0];
        CfgFrameWidth:  frame_width_q  <= cfg_data_i[FrmCfgW-1:0];
        CfgFrameHeight: frame_height_q <= cfg_data_i[FrmCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Raster position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
      bc_q  <= '0;
    end else if (cfg_write && cfg_known) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
      bc_q  <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_q <= '0;
        ox_q  <= '0;
        bc_q  <= '0;
        if (frame_end) begin
          row_q <= '0;
          oy_q  <= '0;
        end else begin
          row_q <= row_q + RowW'(1);
          oy_q  <= row_done ? '0 : oy_q + OffW'(1);
        end
      end else begin
        col_q <= col_q + ColW'(1);
        if (col_done) begin
          ox_q <= '0;
          bc_q <= bc_q + ColW'(1);
        end else begin
          ox_q <= ox_q + OffW'(1);
        end
      end
    end
  end

  // Write-back stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_load_q  <= 1'b0;
      s2_done_q  <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s2_valid_q <= accept;
      if (accept) begin
        s2_load_q <= (ox_q == '0) && (oy_q == '0);
        s2_done_q <= blk_done;
        fwd_q     <= s2_valid_q && (s2_addr_q == bc_q);
      end
    end
  end

  // Write-back stage payload and completed-block description.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_addr_q  <= bc_q;
      s2_px_q    <= px_in;
      fwd_data_q <= s2_sums;
      if (blk_done) begin
        meta_ox_q   <= col_q - ColW'(ox_q);
        meta_oy_q   <= row_q - RowW'(oy_q);
        meta_sx_q   <= span_x;
        meta_sy_q   <= span_y;
        meta_last_q <= frame_end;
        meta_cnt_q  <= CntW'(span_x) * CntW'(span_y);
      end
    end
  end

  // New sums: load at a block's top-left pixel, else add to the forwarded or read value.
  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      if (s2_load_q) s2_sums[ch] = SumW'(s2_px_q[ch]);
      else if (fwd_q) s2_sums[ch] = fwd_data_q[ch] + SumW'(s2_px_q[ch]);
      else s2_sums[ch] = mem_rdata_q[ch] + SumW'(s2_px_q[ch]);
    end
  end

  // Sum memory: read when a pixel is taken, written back in the next cycle.
  always_ff @(posedge clk_i) begin
    if (accept) mem_rdata_q <= sum_mem[bc_q];
    if (s2_valid_q) sum_mem[s2_addr_q] <= s2_sums;
  end

  // One restoring division step per lane; the quotient never exceeds eight bits.
  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      if (rem_q[ch] >= dvs_q) begin
        rem_d[ch] = rem_q[ch] - dvs_q;
        quo_d[ch] = {quo_q[ch][QuoW-2:0], 1'b1};
      end else begin
        rem_d[ch] = rem_q[ch];
        quo_d[ch] = {quo_q[ch][QuoW-2:0], 1'b0};
      end
    end
  end

  assign div_start  = s2_valid_q & s2_done_q;
  assign div_last   = div_step_q == StepW'(QuoW - 1);
  assign div_fire   = div_busy_q & (~div_last | ~out_valid_q | ~out_stall_i);
  assign div_finish = div_fire & div_last;

  // Divider control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_step_q <= '0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
      div_step_q <= '0;
    end else if (div_fire) begin
      div_step_q <= div_step_q + StepW'(1);
      if (div_last) div_busy_q <= 1'b0;
    end
  end

  // Divider datapath.
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      rem_q <= s2_sums;
      dvs_q <= SumW'(meta_cnt_q) << (QuoW - 1);
      quo_q <= '0;
    end else if (div_fire) begin
      rem_q <= rem_d;
      dvs_q <= dvs_q >> 1;
      quo_q <= quo_d;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (div_finish) begin
      origin_x_q <= meta_ox_q;
      origin_y_q <= meta_oy_q;
      span_x_q   <= meta_sx_q;
      span_y_q   <= meta_sy_q;
      avg_q      <= quo_d;
      last_q     <= meta_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign origin_x_o   = origin_x_q;
  assign origin_y_o   = origin_y_q;
  assign span_x_o     = span_x_q;
  assign span_y_o     = span_y_q;
  assign avg_red_o    = avg_q[0];
  assign avg_green_o  = avg_q[1];
  assign avg_blue_o   = avg_q[2];
  assign avg_alpha_o  = avg_q[3];
  assign last_block_o = last_q;

endmodule

// ===== rtl/bap_checker.sv =====
// Port-level checks for block_average_pixelate, attached by the bind below.
// Depends on bap_pkg for widths and the block size limit.
module bap_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bap_pkg::ColW-1:0]      origin_x_o,
  input logic [bap_pkg::RowW-1:0]      origin_y_o,
  input logic [bap_pkg::SpanW-1:0]     span_x_o,
  input logic [bap_pkg::SpanW-1:0]     span_y_o,
  input logic [bap_pkg::PixW-1:0]      avg_red_o,
  input logic [bap_pkg::PixW-1:0]      avg_green_o,
  input logic [bap_pkg::PixW-1:0]      avg_blue_o,
  input logic [bap_pkg::PixW-1:0]      avg_alpha_o,
  input logic                          last_block_o
);
  import bap_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(origin_x_o) && $stable(origin_y_o) &&
      $stable(span_x_o) && $stable(span_y_o) && $stable(avg_red_o) &&
      $stable(avg_green_o) && $stable(avg_blue_o) && $stable(avg_alpha_o) &&
      $stable(last_block_o))
    else $error("result payload changed while stalled");

  // Block spans always lie within one to the largest block size.
  a_span_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> span_x_o != '0 && span_x_o <= SpanW'(MAX_BLOCK) &&
      span_y_o != '0 && span_y_o <= SpanW'(MAX_BLOCK))
    else $error("block span out of range");

  // A new result comes out of the divider, which holds off pixels while it runs.
  a_result_after_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a division in progress");

endmodule

bind block_average_pixelate bap_checker u_bap_checker (.*);
